>>> rtl/core/brl_pkg.sv
// Shared types, constants and codes for the line rasterizer.
package brl_pkg;

    localparam int COORD_BITS   = 10;
    localparam int SCR_BITS     = 11;
    localparam int COLOR_BITS   = 16;
    localparam int ERR_BITS     = COORD_BITS + 3;
    localparam int E2_BITS      = ERR_BITS + 1;
    localparam int CMP_BITS     = (COORD_BITS > SCR_BITS) ? COORD_BITS : SCR_BITS;
    localparam int CFG_IDX_BITS = 2;
    localparam int CMD_DEPTH_DEF = 2;

    localparam logic [SCR_BITS-1:0] SCREEN_WIDTH_RST  = SCR_BITS'(320);
    localparam logic [SCR_BITS-1:0] SCREEN_HEIGHT_RST = SCR_BITS'(240);

    // Action codes.
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);

    typedef struct packed {
        logic                  action;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] stop_x;
        logic [COORD_BITS-1:0] stop_y;
        logic [COLOR_BITS-1:0] pen_color;
    } request_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  on_screen;
        logic [COORD_BITS-1:0] panel_column;
        logic                  last;
    } pixel_t;

    // Classified command from front to back.
    typedef struct packed {
        logic                  action;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] stop_x;
        logic [COORD_BITS-1:0] stop_y;
        logic [COORD_BITS-1:0] delta_x;
        logic [COORD_BITS-1:0] delta_y;
        logic                  dir_x;
        logic                  dir_y;
        logic [ERR_BITS-1:0]   err_term;
        logic [COLOR_BITS-1:0] color;
    } cmd_t;

    typedef struct packed {
        logic [SCR_BITS-1:0] width;
        logic [SCR_BITS-1:0] height;
    } screen_cfg_t;

endpackage

>>> rtl/core/brl_front.sv
// Front end: accepts request words and works out spans, directions and initial error.
module brl_front
    import brl_pkg::*;
(
    input  logic     push,
    output logic     full,
    input  request_t request,
    input  logic     cmd_full,
    output logic     cmd_push,
    output cmd_t     cmd
);

    logic                  dir_x;
    logic                  dir_y;
    logic [COORD_BITS-1:0] span_x;
    logic [COORD_BITS-1:0] span_y;

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;

    always_comb
    begin
        dir_x  = request.stop_x < request.start_x;
        dir_y  = request.stop_y < request.start_y;
        span_x = dir_x ? (request.start_x - request.stop_x) : (request.stop_x - request.start_x);
        span_y = dir_y ? (request.start_y - request.stop_y) : (request.stop_y - request.start_y);

        cmd.action   = request.action;
        cmd.start_x  = request.start_x;
        cmd.start_y  = request.start_y;
        cmd.stop_x   = request.stop_x;
        cmd.stop_y   = request.stop_y;
        cmd.delta_x  = span_x;
        cmd.delta_y  = span_y;
        cmd.dir_x    = dir_x;
        cmd.dir_y    = dir_y;
        cmd.err_term = {{(ERR_BITS-COORD_BITS){1'b0}}, span_x}
                     - {{(ERR_BITS-COORD_BITS){1'b0}}, span_y};
        cmd.color    = request.pen_color;
    end

endmodule

>>> rtl/core/brl_cmd_fifo.sv
// Short command queue between front end and stepper.
module brl_cmd_fifo
    import brl_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = entry_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("command queue count past depth");

endmodule

>>> rtl/core/brl_back.sv
// Stepper: holds the line state, runs the Bresenham step and registers each pixel word.
module brl_back
    import brl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  screen_cfg_t screen,
    input  cmd_t        cmd,
    input  logic        cmd_empty,
    output logic        cmd_pop,
    output pixel_t      result,
    output logic        empty,
    input  logic        pop
);

    logic                  busy_reg;
    logic                  busy_next;
    logic [COORD_BITS-1:0] cur_x_reg;
    logic [COORD_BITS-1:0] cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg;
    logic [COORD_BITS-1:0] cur_y_next;
    logic [COORD_BITS-1:0] end_x_reg;
    logic [COORD_BITS-1:0] end_x_next;
    logic [COORD_BITS-1:0] end_y_reg;
    logic [COORD_BITS-1:0] end_y_next;
    logic [COORD_BITS-1:0] delta_x_reg;
    logic [COORD_BITS-1:0] delta_x_next;
    logic [COORD_BITS-1:0] delta_y_reg;
    logic [COORD_BITS-1:0] delta_y_next;
    logic                  dir_x_reg;
    logic                  dir_x_next;
    logic                  dir_y_reg;
    logic                  dir_y_next;
    logic [ERR_BITS-1:0]   err_reg;
    logic [ERR_BITS-1:0]   err_next;
    logic [COLOR_BITS-1:0] color_reg;
    logic [COLOR_BITS-1:0] color_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    pixel_t                result_reg;
    pixel_t                result_next;

    logic                  fire;
    logic                  emit;
    logic                  is_load;
    logic signed [E2_BITS-1:0] e2;
    logic signed [E2_BITS-1:0] sdx;
    logic signed [E2_BITS-1:0] sdy;
    logic signed [E2_BITS-1:0] err_sum;
    logic                  step_x;
    logic                  step_y;
    logic [CMP_BITS-1:0]   x_ext;
    logic [CMP_BITS-1:0]   y_ext;
    logic [CMP_BITS-1:0]   panel_full;
    logic                  on;
    logic                  fin;

    // Take a command whenever the output slot is free or being drained this cycle.
    assign fire    = !cmd_empty && (!out_valid_reg || pop);
    assign cmd_pop = fire;
    assign is_load = cmd.action == ACT_LOAD;
    assign emit    = fire && (is_load || busy_reg);
    assign empty   = !out_valid_reg;
    assign result  = result_reg;

    always_comb
    begin
        e2      = signed'({err_reg[ERR_BITS-1], err_reg}) <<< 1;
        sdx     = signed'({{(E2_BITS-COORD_BITS){1'b0}}, delta_x_reg});
        sdy     = signed'({{(E2_BITS-COORD_BITS){1'b0}}, delta_y_reg});
        step_x  = e2 >= -sdy;
        step_y  = e2 <= sdx;
        err_sum = signed'({err_reg[ERR_BITS-1], err_reg})
                - (step_x ? sdy : '0) + (step_y ? sdx : '0);

        busy_next    = busy_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        end_x_next   = end_x_reg;
        end_y_next   = end_y_reg;
        delta_x_next = delta_x_reg;
        delta_y_next = delta_y_reg;
        dir_x_next   = dir_x_reg;
        dir_y_next   = dir_y_reg;
        err_next     = err_reg;
        color_next   = color_reg;

        if (fire && is_load)
        begin
            cur_x_next   = cmd.start_x;
            cur_y_next   = cmd.start_y;
            end_x_next   = cmd.stop_x;
            end_y_next   = cmd.stop_y;
            delta_x_next = cmd.delta_x;
            delta_y_next = cmd.delta_y;
            dir_x_next   = cmd.dir_x;
            dir_y_next   = cmd.dir_y;
            err_next     = cmd.err_term;
            color_next   = cmd.color;
        end
        else if (emit)
        begin
            err_next = err_sum[ERR_BITS-1:0];
            if (step_x)
            begin
                cur_x_next = dir_x_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
            end
            if (step_y)
            begin
                cur_y_next = dir_y_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            end
        end

        x_ext      = CMP_BITS'(cur_x_next);
        y_ext      = CMP_BITS'(cur_y_next);
        on         = (x_ext < CMP_BITS'(screen.width))
                  && (y_ext < CMP_BITS'(screen.height));
        panel_full = CMP_BITS'(screen.height) - 1'b1 - y_ext;
        fin        = (cur_x_next == end_x_next) && (cur_y_next == end_y_next);

        if (emit)
        begin
            busy_next = !fin;
        end

        result_next.pixel_x      = cur_x_next;
        result_next.pixel_y      = cur_y_next;
        result_next.pixel_color  = color_next;
        result_next.on_screen    = on;
        result_next.panel_column = on ? panel_full[COORD_BITS-1:0] : '0;
        result_next.last         = fin;

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            end_x_reg     <= '0;
            end_y_reg     <= '0;
            delta_x_reg   <= '0;
            delta_y_reg   <= '0;
            dir_x_reg     <= 1'b0;
            dir_y_reg     <= 1'b0;
            err_reg       <= '0;
            color_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            end_x_reg     <= end_x_next;
            end_y_reg     <= end_y_next;
            delta_x_reg   <= delta_x_next;
            delta_y_reg   <= delta_y_next;
            dir_x_reg     <= dir_x_next;
            dir_y_reg     <= dir_y_next;
            err_reg       <= err_next;
            color_reg     <= color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && fin) |=> !busy_reg)
        else $error("final pixel did not leave the stepper idle");

    a_idle_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !emit) |=> !out_valid_reg)
        else $error("dropped advance produced a pixel word");

    a_unit_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !is_load) |=>
            (cur_x_reg == $past(cur_x_reg)) || (cur_x_reg == $past(cur_x_reg) + 1'b1)
            || (cur_x_reg == $past(cur_x_reg) - 1'b1))
        else $error("x moved more than one pixel in a step");

endmodule

>>> rtl/core/bresenham_line_rasterizer.sv
// Line rasterizer top level: one pixel word per clock while commands are queued and pop drains
// the output slot; a request word enters the command queue, then its pixel word is registered in
// the stepper's output slot. Its combinational error update and registered output slot set that
// rate; the command queue is CMD_DEPTH words deep. Screen size registers reset to 320 by 240.
module bresenham_line_rasterizer
    import brl_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  request_t                request,
    output logic                    empty,
    input  logic                    pop,
    output pixel_t                  pixel,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SCR_BITS-1:0]     cfg_data
);

    screen_cfg_t screen_reg;
    screen_cfg_t screen_next;
    logic        cmd_push;
    cmd_t        cmd_in;
    logic        cmd_full;
    logic        cmd_pop;
    cmd_t        cmd_out;
    logic        cmd_empty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        screen_next = screen_reg;
        if (cfg_valid)
        begin
            // Drop writes to indexes beyond the register list.
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  screen_next.width  = cfg_data;
                REG_SCREEN_HEIGHT: screen_next.height = cfg_data;
                default:           screen_next = screen_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_reg.width  <= SCREEN_WIDTH_RST;
            screen_reg.height <= SCREEN_HEIGHT_RST;
        end
        else
        begin
            screen_reg <= screen_next;
        end
    end

    brl_front u_front (
        .push     (push),
        .full     (full),
        .request  (request),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    brl_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    brl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .screen    (screen_reg),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .result    (pixel),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
